FILE: design/track_crc32_with_timestamp_core_macros.svh
// Assertion macros for the track CRC core.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef TRACK_CRC32_WITH_TIMESTAMP_CORE_MACROS_SVH
`define TRACK_CRC32_WITH_TIMESTAMP_CORE_MACROS_SVH

// checked out of reset only
`define TCTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TCTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/tcts_pkg.sv
// Shared types and constants for the track CRC core.
// No dependencies.
package tcts_pkg;

  localparam logic [31:0] CrcPoly   = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [11:0] YearBase  = 12'd1980;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_byte;
    logic        first_track;
    logic        stamp_valid;
    logic [4:0]  stamp_hour;
    logic [5:0]  stamp_minute;
    logic [5:0]  stamp_second;
    logic [11:0] stamp_year;
    logic [3:0]  stamp_month;
    logic [4:0]  stamp_day;
  } in_req_t;

  typedef struct packed {
    logic [31:0] track_crc;
    logic [31:0] crc_sum;
  } out_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_STAMP  = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_SPARE  = 5'b10000
  } state_e;

endpackage

FILE: design/track_crc32_with_timestamp_core.sv
// Track CRC core: sequencer around a shared byte-step CRC unit, output register.
// Depends on tcts_pkg, tcts_crc_step and the core macros header.
//
//  channel | dir | payload   | handshake
//  in      | in  | in_req_t  | in_valid_i / in_stall_o
//  out     | out | out_rsp_t | out_valid_o / out_stall_i
//
// An item that does not end a track leaves the sequencer idle, so the next item is not stalled.
// A track's last item is followed by p zero pad bytes (0..3) and, if the stamp flag s is set, four stamp bytes;
// one byte goes through the shared CRC unit per cycle.
// The finish step waits while an earlier result is still stalled in the output register.
// Reset: CRC all ones, phase and sum zero, no result pending.
`include "track_crc32_with_timestamp_core_macros.svh"

module track_crc32_with_timestamp_core import tcts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_data_o
);

  state_e      state_q, state_d;
  logic [31:0] crc_q, crc_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] sum_q, sum_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        stamp_q, stamp_d;
  logic        first_q, first_d;
  logic [31:0] words_q, words_d;
  logic        out_valid_q, out_valid_d;
  out_rsp_t    out_q, out_d;

  logic [31:0] unit_crc;
  logic [7:0]  unit_byte;
  logic        in_acc;
  logic        slot_free;
  logic [15:0] tword, dword;
  logic [6:0]  year_off;

  tcts_crc_step u_step (
    .crc_i  (crc_q),
    .byte_i (unit_byte),
    .crc_o  (unit_crc)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign year_off = 7'(in_data_i.stamp_year - YearBase);
  assign tword = {in_data_i.stamp_hour, in_data_i.stamp_minute, in_data_i.stamp_second[5:1]};
  assign dword = {year_off, in_data_i.stamp_month, in_data_i.stamp_day};

  always_comb begin
    state_d     = state_q;
    crc_d       = crc_q;
    phase_d     = phase_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    stamp_d     = stamp_q;
    first_d     = first_q;
    words_d     = words_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unit_byte   = '0;

    unique case (state_q)
      ST_IDLE: begin
        unit_byte = in_data_i.data_byte;
        if (in_acc) begin
          if (in_data_i.has_byte) begin
            crc_d   = unit_crc;
            phase_d = phase_q + 2'd1;
          end
          if (in_data_i.last_byte) begin
            stamp_d = in_data_i.stamp_valid;
            first_d = in_data_i.first_track;
            words_d = {dword, tword};
            cnt_d   = '0;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (phase_q != 2'd0) begin
          crc_d   = unit_crc;
          phase_d = phase_q + 2'd1;
        end else begin
          state_d = stamp_q ? ST_STAMP : ST_FINISH;
        end
      end
      ST_STAMP: begin
        unit_byte = words_q[8*cnt_q +: 8];
        crc_d     = unit_crc;
        cnt_d     = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          sum_d           = (first_q ? 32'h0 : sum_q) + crc_q;
          out_d.track_crc = crc_q;
          out_d.crc_sum   = sum_d;
          out_valid_d     = 1'b1;
          crc_d           = CrcInit;
          phase_d         = '0;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      crc_q       <= CrcInit;
      phase_q     <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      crc_q       <= crc_d;
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    first_q <= first_d;
    words_q <= words_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TCTS_ASSERT(a_finish_waits, (state_q == ST_FINISH && out_valid_q && out_stall_i) |=> (state_q == ST_FINISH && $stable(out_q)), "result overwritten while stalled")
  `TCTS_ASSERT(a_finish_clears, (state_q == ST_FINISH && slot_free) |=> (state_q == ST_IDLE && phase_q == 2'd0 && crc_q == CrcInit), "track state not cleared after finish")
  `TCTS_ASSERT(a_pad_exit, (state_q == ST_PAD && phase_q == 2'd0) |=> (state_q != ST_PAD), "padding did not end on phase zero")
  `TCTS_ASSERT(a_stamp_only_valid, (state_q == ST_STAMP) |-> stamp_q, "stamp bytes fed without a valid stamp")
  `TCTS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE && !out_valid_q), "core not idle in reset")

endmodule

FILE: design/tcts_crc_step.sv
// One byte step of MSB-first CRC-32, shared by data, padding and stamp bytes.
// Depends on tcts_pkg.
module tcts_crc_step import tcts_pkg::*; (
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {byte_i, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CrcPoly) : {c[30:0], 1'b0};
    end
    crc_o = c;
  end

endmodule

FILE: tb/track_crc32_with_timestamp_core_tb.sv
// Testbench for track_crc32_with_timestamp_core: directed and random tracks with
// idling on both sides; a scoreboard class predicts each track CRC and running sum.
// Depends on tcts_pkg and the core RTL.
`timescale 1ns / 1ps

module track_crc32_with_timestamp_core_tb import tcts_pkg::*; ();

  class crc_scoreboard;
    logic [31:0] crc_acc;
    logic [1:0]  phase;
    logic [31:0] sum_acc;
    out_rsp_t    expected_q[$];
    int unsigned errors;
    int unsigned n_checked;

    function new();
      crc_acc   = CrcInit;
      phase     = '0;
      sum_acc   = '0;
      errors    = 0;
      n_checked = 0;
    endfunction

    function logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
      c = c ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) begin
        c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
    endfunction

    function void note_request(in_req_t r);
      logic [31:0] tword;
      logic [31:0] dword;
      out_rsp_t    rsp;
      if (r.has_byte) begin
        crc_acc = crc_byte(crc_acc, r.data_byte);
        phase   = phase + 2'd1;
      end
      if (!r.last_byte) return;
      while (phase != 2'd0) begin
        crc_acc = crc_byte(crc_acc, 8'h00);
        phase   = phase + 2'd1;
      end
      if (r.stamp_valid) begin
        tword = (32'(r.stamp_hour) << 11) | (32'(r.stamp_minute) << 5)
              | (32'(r.stamp_second) >> 1);
        dword = ((32'(r.stamp_year) - 32'(YearBase)) << 9)
              | (32'(r.stamp_month) << 5) | 32'(r.stamp_day);
        crc_acc = crc_byte(crc_acc, tword[7:0]);
        crc_acc = crc_byte(crc_acc, tword[15:8]);
        crc_acc = crc_byte(crc_acc, dword[7:0]);
        crc_acc = crc_byte(crc_acc, dword[15:8]);
      end
      if (r.first_track) sum_acc = '0;
      sum_acc       = sum_acc + crc_acc;
      rsp.track_crc = crc_acc;
      rsp.crc_sum   = sum_acc;
      expected_q.push_back(rsp);
      crc_acc = CrcInit;
      phase   = '0;
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: unexpected result crc %h sum %h", $time, got.track_crc, got.crc_sum);
        return;
      end
      want = expected_q.pop_front();
      if (got.track_crc !== want.track_crc) begin
        errors++;
        if (errors <= 200)
          $display("%0t: track_crc expected %h actual %h", $time, want.track_crc,
                   got.track_crc);
      end
      if (got.crc_sum !== want.crc_sum) begin
        errors++;
        if (errors <= 200)
          $display("%0t: crc_sum expected %h actual %h", $time, want.crc_sum, got.crc_sum);
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_data_o;

  crc_scoreboard crc_sb = new();

  track_crc32_with_timestamp_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_req_t track_item(logic [7:0] b, bit has, bit last, bit first,
                                         bit stamp, bit wild);
    in_req_t r;
    r.data_byte   = b;
    r.has_byte    = has;
    r.last_byte   = last;
    r.first_track = first;
    r.stamp_valid = stamp;
    if (wild) begin
      r.stamp_hour   = 5'($urandom);
      r.stamp_minute = 6'($urandom);
      r.stamp_second = 6'($urandom);
      r.stamp_year   = 12'($urandom);
      r.stamp_month  = 4'($urandom);
      r.stamp_day    = 5'($urandom);
    end else begin
      r.stamp_hour   = 5'($urandom_range(0, 23));
      r.stamp_minute = 6'($urandom_range(0, 59));
      r.stamp_second = 6'($urandom_range(0, 59));
      r.stamp_year   = 12'($urandom_range(1980, 2107));
      r.stamp_month  = 4'($urandom_range(1, 12));
      r.stamp_day    = 5'($urandom_range(1, 31));
    end
    return r;
  endfunction

  task automatic send_req(input in_req_t r, input bit may_idle);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    crc_sb.note_request(r);
    if (may_idle && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (crc_sb.expected_q.size() != 0);
  endtask

  // receive side
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) crc_sb.check_result(out_data_o);
      if (crc_sb.n_checked >= 25 && crc_sb.n_checked < 45) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(0, 99) < 38);
    end
  end

  initial begin
    in_req_t r;
    int      len;
    int      n_items;
    bit      mid_drained;
    bit      may_idle;
    n_items     = 0;
    mid_drained = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty tracks, with and without stamp, then a one-byte track with stamp
    send_req(track_item(8'h00, 0, 1, 1, 0, 0), 1);
    r = track_item(8'h00, 0, 1, 0, 1, 0);
    r.stamp_hour  = 0;  r.stamp_minute = 0;  r.stamp_second = 0;
    r.stamp_year  = 12'd1980; r.stamp_month = 1; r.stamp_day = 1;
    send_req(r, 1);
    r = track_item(8'h00, 1, 1, 0, 1, 0);
    r.stamp_hour  = 23; r.stamp_minute = 59; r.stamp_second = 59;
    r.stamp_year  = 12'd2107; r.stamp_month = 12; r.stamp_day = 31;
    send_req(r, 1);
    // flags on a mid-track item are ignored
    send_req(track_item(8'hFF, 1, 0, 1, 1, 1), 1);
    send_req(track_item(8'hA5, 1, 1, 0, 0, 0), 1);
    send_req(track_item(8'h01, 1, 0, 0, 0, 0), 1);
    send_req(track_item(8'h3C, 0, 0, 1, 1, 1), 1);
    send_req(track_item(8'h80, 1, 0, 0, 0, 0), 1);
    r = track_item(8'h7F, 1, 1, 0, 1, 0);
    r.stamp_hour  = 31; r.stamp_minute = 63; r.stamp_second = 63;
    r.stamp_year  = 12'd4095; r.stamp_month = 15; r.stamp_day = 31;
    send_req(r, 1);
    send_req(track_item(8'h55, 1, 0, 0, 0, 0), 1);
    send_req(track_item(8'hAA, 1, 0, 0, 0, 0), 1);
    send_req(track_item(8'h0F, 1, 0, 0, 0, 0), 1);
    r = track_item(8'hF0, 1, 1, 0, 1, 0);
    r.stamp_hour  = 0; r.stamp_minute = 0; r.stamp_second = 1;
    r.stamp_year  = 12'd0; r.stamp_month = 0; r.stamp_day = 0;
    send_req(r, 1);
    send_req(track_item(8'hDE, 1, 0, 0, 0, 0), 1);
    send_req(track_item(8'hAD, 1, 0, 0, 0, 0), 1);
    send_req(track_item(8'hBE, 1, 0, 0, 0, 0), 1);
    send_req(track_item(8'hEF, 1, 0, 0, 0, 0), 1);
    send_req(track_item(8'h12, 1, 0, 0, 0, 0), 1);
    r = track_item(8'h99, 0, 1, 1, 1, 0);
    r.stamp_year = 12'd1979;
    send_req(r, 1);
    drain_results();

    while (n_items < 900) begin
      may_idle = !(n_items >= 200 && n_items < 350);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_req(track_item(8'($urandom), 0, 0, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1), may_idle);
        send_req(track_item(8'($urandom), 1, 0, $urandom_range(0, 99) < 15,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), may_idle);
        n_items++;
      end
      send_req(track_item(8'($urandom), 1'($urandom_range(0, 1)), 1,
                          $urandom_range(0, 99) < 15, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 99) < 20), may_idle);
      n_items++;
      if (!mid_drained && n_items >= 450) begin
        drain_results();
        mid_drained = 1;
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (crc_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
